@@ design/assert_macros.svh @@
// Assertion macros shared by the sample FIFO modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ design/psfv_pkg.sv @@
// Types and constants of the PCM sample FIFO with master volume.
package psfv_pkg;

    localparam int OP_W     = 3;
    localparam int BYTE_W   = 8;
    localparam int SAMPLE_W = 16;
    localparam int FILL_W   = 10;
    localparam int VOL_W    = 8;
    localparam int VOL_IDX_W = 4;
    localparam int GAIN_W   = 8;
    localparam int GAIN_SHIFT = 8;
    localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_PAD_W  = OUT_DATA_W - SAMPLE_W - FILL_W - 2;

    localparam logic [OP_W-1:0] OP_LATCH_HI    = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_LO     = 3'd1;
    localparam logic [OP_W-1:0] OP_PULL        = 3'd2;
    localparam logic [OP_W-1:0] OP_READ_COUNT  = 3'd3;
    localparam logic [OP_W-1:0] OP_WRITE_FLAGS = 3'd4;

    localparam logic [GAIN_W-1:0] GAIN_TABLE [2**VOL_IDX_W] = '{
        8'd0,   8'd2,   8'd4,   8'd8,   8'd16,  8'd24,  8'd32,  8'd48,
        8'd64,  8'd80,  8'd96,  8'd128, 8'd160, 8'd192, 8'd224, 8'd255
    };

    typedef struct packed {
        logic accept;
        logic prod_en;
        logic out_load;
        logic out_sample;
    } t_cmd;

    typedef struct packed {
        logic pop;
    } t_stat;

endpackage

@@ design/psfv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module psfv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/psfv_ctrl.sv @@
// Controller state machine: input acceptance, read/scale sequencing, output beat valid.
`include "assert_macros.svh"
module psfv_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  logic            i_m_tready,
    input  psfv_pkg::t_stat i_stat,
    output psfv_pkg::t_cmd  o_cmd,
    output logic            o_s_tready,
    output logic            o_m_tvalid
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_pop, n_pop;
    logic       r_out_valid, n_out_valid;
    psfv_pkg::t_cmd w_cmd;

    always_comb begin
        n_state = r_state;
        n_pop   = r_pop;
        w_cmd   = '0;
        w_cmd.out_sample = r_pop;
        case (r_state)
            S_IDLE: begin
                w_cmd.accept = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_pop   = i_stat.pop;
                    n_state = i_stat.pop ? S_READ : S_OUT;
                end
            end
            S_READ: begin
                w_cmd.prod_en = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                // load only when the output register is free or drains now
                w_cmd.out_load = !r_out_valid || i_m_tready;
                if (w_cmd.out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pop       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pop       <= n_pop;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd      = w_cmd;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

    `ASSERT_CLK(a_load_free, i_clk, i_rst_n, w_cmd.out_load |-> (!r_out_valid || i_m_tready))
    `ASSERT_CLK(a_pop_reads, i_clk, i_rst_n, (w_cmd.accept && i_stat.pop) |=> (r_state == S_READ))
    `ASSERT_CLK(a_load_done, i_clk, i_rst_n, w_cmd.out_load |=> (r_state == S_IDLE && r_out_valid))

endmodule

@@ design/psfv_dp.sv @@
// Datapath: ring pointers, fill count, flags, sample latch, volume scaling, output register.
`include "assert_macros.svh"
module psfv_dp #(
    parameter int FIFO_DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  psfv_pkg::t_cmd                      i_cmd,
    input  logic [psfv_pkg::OP_W-1:0]           i_op,
    input  logic [psfv_pkg::BYTE_W-1:0]         i_data,
    input  logic                                i_cfg_we,
    input  logic [psfv_pkg::VOL_W-1:0]          i_cfg_data,
    output psfv_pkg::t_stat                     o_stat,
    output logic [psfv_pkg::OUT_DATA_W-1:0]     o_out_data
);

    localparam int CW  = $clog2(FIFO_DEPTH);
    localparam int CXW = (CW > psfv_pkg::FILL_W) ? CW : psfv_pkg::FILL_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] HALF_CNT = CW'(FIFO_DEPTH / 2);
    localparam logic [CW-1:0] LAST_PTR = CW'(FIFO_DEPTH - 1);

    logic [CW-1:0] r_wp, n_wp, r_rp, n_rp, r_count, n_count;
    logic [psfv_pkg::SAMPLE_W-1:0] r_latch, n_latch, w_sample;
    logic r_full, n_full, r_wm, n_wm;
    logic [psfv_pkg::VOL_W-1:0] r_vol;
    logic w_ram_we, w_ram_re;
    logic [psfv_pkg::SAMPLE_W-1:0] w_rdata;
    logic signed [psfv_pkg::PROD_W-1:0] r_prod, w_shift;
    logic signed [psfv_pkg::SAMPLE_W-1:0] w_scaled;
    logic [CXW-1:0] w_count_x;
    logic [psfv_pkg::OUT_DATA_W-1:0] r_out_data;

    function automatic logic [CW-1:0] f_inc(input logic [CW-1:0] p);
        f_inc = (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    assign o_stat.pop = (i_op == psfv_pkg::OP_PULL) && (r_count != '0);
    assign w_sample   = r_latch | {{(psfv_pkg::SAMPLE_W - psfv_pkg::BYTE_W){1'b0}}, i_data};

    always_comb begin
        n_wp     = r_wp;
        n_rp     = r_rp;
        n_count  = r_count;
        n_latch  = r_latch;
        n_full   = r_full;
        n_wm     = r_wm;
        w_ram_we = 1'b0;
        w_ram_re = 1'b0;
        if (i_cmd.accept) begin
            case (i_op)
                psfv_pkg::OP_LATCH_HI: begin
                    n_latch = {i_data, {(psfv_pkg::SAMPLE_W - psfv_pkg::BYTE_W){1'b0}}};
                end
                psfv_pkg::OP_PUSH_LO: begin
                    // drop the sample when the ring is full, clear the latch anyway
                    if (r_count != FULL_CNT) begin
                        w_ram_we = 1'b1;
                        n_wp     = f_inc(r_wp);
                        n_count  = r_count + 1'b1;
                        if (r_count + 1'b1 == FULL_CNT) begin
                            n_full = 1'b1;
                        end
                    end
                    n_latch = '0;
                end
                psfv_pkg::OP_PULL: begin
                    if (r_count != '0) begin
                        w_ram_re = 1'b1;
                        n_rp     = f_inc(r_rp);
                        n_count  = r_count - 1'b1;
                        n_full   = 1'b0;
                        if (r_count - 1'b1 < HALF_CNT) begin
                            n_wm = 1'b1;
                        end
                    end
                end
                psfv_pkg::OP_READ_COUNT: begin
                end
                psfv_pkg::OP_WRITE_FLAGS: begin
                    n_full = i_data[0];
                    n_wm   = i_data[1];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
            r_latch <= '0;
            r_full  <= 1'b0;
            r_wm    <= 1'b0;
            r_vol   <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
            r_latch <= n_latch;
            r_full  <= n_full;
            r_wm    <= n_wm;
            if (i_cfg_we) begin
                r_vol <= i_cfg_data;
            end
        end
    end

    psfv_ram #(
        .WIDTH (psfv_pkg::SAMPLE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wp),
        .i_wdata (w_sample),
        .i_re    (w_ram_re),
        .i_raddr (r_rp),
        .o_rdata (w_rdata)
    );

    // gain is unsigned, so widen it with a zero sign bit
    always_ff @(posedge i_clk) begin
        if (i_cmd.prod_en) begin
            r_prod <= $signed(w_rdata)
                * $signed({1'b0, psfv_pkg::GAIN_TABLE[r_vol[psfv_pkg::VOL_IDX_W-1:0]]});
        end
    end

    assign w_shift = r_prod >>> psfv_pkg::GAIN_SHIFT;

    always_comb begin
        if (w_shift > $signed(psfv_pkg::PROD_W'(32767))) begin
            w_scaled = 16'sh7FFF;
        end else if (w_shift < -$signed(psfv_pkg::PROD_W'(32768))) begin
            w_scaled = 16'sh8000;
        end else begin
            w_scaled = w_shift[psfv_pkg::SAMPLE_W-1:0];
        end
    end

    assign w_count_x = CXW'(r_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {{psfv_pkg::OUT_PAD_W{1'b0}}, r_wm, r_full,
                           w_count_x[psfv_pkg::FILL_W-1:0],
                           i_cmd.out_sample ? w_scaled : {psfv_pkg::SAMPLE_W{1'b0}}};
        end
    end

    assign o_out_data = r_out_data;

    `ASSERT_CLK(a_count_range, i_clk, i_rst_n, r_count <= FULL_CNT)
    `ASSERT_CLK(a_full_drop, i_clk, i_rst_n, (i_cmd.accept && i_op == psfv_pkg::OP_PUSH_LO && r_count == FULL_CNT) |=> $stable(r_wp))
    `ASSERT_CLK(a_pop_clears, i_clk, i_rst_n, (i_cmd.accept && o_stat.pop) |=> (!r_full && r_count == $past(r_count) - 1'b1))

endmodule

@@ design/pcm_sample_fifo_with_volume.sv @@
// Top level of the PCM sample FIFO with master volume.
//
// Input beats carry a bus operation in s_axis_tuser and a byte in s_axis_tdata:
// latch high byte, push low byte, pull frame, read count or write flags.
// Every input beat yields exactly one output beat on m_axis with the scaled
// sample (zero unless a pull pops), the fill count and both status flags.
// The master volume register is written through i_cfg_we / i_cfg_data; the user must
// do so only while idle, as the block itself does not enforce it. A popping pull
// reads the ring at acceptance, registers the volume multiply, then saturates and
// loads the output register; other operations go straight to the output load.
// The sequencing controller works on one item at a time, until its result is loaded.
// The output register frees the input side: a new beat is accepted while a
// finished result still waits; when the receiver stalls, the next result
// holds inside the block and s_axis_tready stays low until it can be loaded.
// Reset empties the ring, clears the latch, flags and volume; ring contents
// stay undefined and need no clearing pass.
module pcm_sample_fifo_with_volume #(
    parameter int FIFO_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [2:0]  s_axis_tuser,   // [2:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [15:0] audio_sample, [25:16] fill_count,
                                        // [26] fifo_full, [27] low_watermark, [31:28] zero
);

    psfv_pkg::t_cmd  w_cmd;
    psfv_pkg::t_stat w_stat;

    psfv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid)
    );

    psfv_dp #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_op       (s_axis_tuser),
        .i_data     (s_axis_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_stat     (w_stat),
        .o_out_data (m_axis_tdata)
    );

endmodule

@@ tb/pcm_fifo_checker.sv @@
// Checker for the PCM sample FIFO: tracks the FIFO state and compares every output beat.
module pcm_fifo_checker #(
    parameter int DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_data,
    input  logic [2:0]  i_in_op,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,
    output int          o_failures,
    output int          o_pending
);

    typedef struct packed {
        logic signed [15:0] sample;
        logic [9:0]         fill;
        logic               full;
        logic               low_wm;
    } t_fifo_status;

    logic [15:0]  ring_mem [DEPTH];
    int           wr_ptr;
    int           rd_ptr;
    logic [15:0]  hi_latch;
    logic         full_flag;
    logic         wm_flag;
    logic [7:0]   volume;
    t_fifo_status status_q [$];

    initial o_failures = 0;
    initial o_pending = 0;

    function automatic int gain_of(input logic [3:0] idx);
        case (idx)
            4'd0:  return 0;
            4'd1:  return 2;
            4'd2:  return 4;
            4'd3:  return 8;
            4'd4:  return 16;
            4'd5:  return 24;
            4'd6:  return 32;
            4'd7:  return 48;
            4'd8:  return 64;
            4'd9:  return 80;
            4'd10: return 96;
            4'd11: return 128;
            4'd12: return 160;
            4'd13: return 192;
            4'd14: return 224;
            default: return 255;
        endcase
    endfunction

    // Floor of sample * gain / 256, clamped to 16 bits signed.
    function automatic logic [15:0] scale_by_volume(input logic [15:0] raw,
                                                   input logic [3:0] idx);
        int s;
        int prod;
        s = $signed(raw);
        prod = (s * gain_of(idx)) >>> 8;
        if (prod > 32767)
            prod = 32767;
        else if (prod < -32768)
            prod = -32768;
        return prod[15:0];
    endfunction

    task automatic step_fifo(input logic [2:0] op, input logic [7:0] data);
        t_fifo_status st;
        int nxt;
        int left;
        st = '0;
        case (op)
            psfv_pkg::OP_LATCH_HI: hi_latch = {data, 8'h00};
            psfv_pkg::OP_PUSH_LO: begin
                nxt = (wr_ptr + 1) % DEPTH;
                // drop the sample when the ring is full, clear the latch anyway
                if (nxt != rd_ptr) begin
                    ring_mem[wr_ptr] = hi_latch | {8'h00, data};
                    wr_ptr = nxt;
                    if ((nxt + 1) % DEPTH == rd_ptr)
                        full_flag = 1'b1;
                end
                hi_latch = '0;
            end
            psfv_pkg::OP_PULL: begin
                if (wr_ptr != rd_ptr) begin
                    left = (wr_ptr - rd_ptr + DEPTH) % DEPTH - 1;
                    st.sample = scale_by_volume(ring_mem[rd_ptr], volume[3:0]);
                    rd_ptr = (rd_ptr + 1) % DEPTH;
                    full_flag = 1'b0;
                    if (left < DEPTH / 2)
                        wm_flag = 1'b1;
                end
            end
            psfv_pkg::OP_WRITE_FLAGS: begin
                full_flag = data[0];
                wm_flag = data[1];
            end
            default: ;  // read count and unused codes leave the state alone
        endcase
        st.fill = 10'((wr_ptr - rd_ptr + DEPTH) % DEPTH);
        st.full = full_flag;
        st.low_wm = wm_flag;
        status_q.push_back(st);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_failures++;
        end
    endtask

    always @(posedge i_clk) begin
        t_fifo_status want;
        if (!i_rst_n) begin
            wr_ptr = 0;
            rd_ptr = 0;
            hi_latch = '0;
            full_flag = 1'b0;
            wm_flag = 1'b0;
            volume = '0;
            status_q.delete();
        end else begin
            if (i_cfg_we)
                volume = i_cfg_data;
            if (i_in_valid && i_in_ready)
                step_fifo(i_in_op, i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (status_q.size() == 0) begin
                    $error("output beat with no pending item: tdata %h", i_out_data);
                    o_failures++;
                end else begin
                    want = status_q.pop_front();
                    check_field("audio_sample", int'(want.sample),
                                int'($signed(i_out_data[15:0])));
                    check_field("fill_count", int'(want.fill), int'(i_out_data[25:16]));
                    check_field("fifo_full", int'(want.full), int'(i_out_data[26]));
                    check_field("low_watermark", int'(want.low_wm), int'(i_out_data[27]));
                    check_field("tdata_pad", 0, int'(i_out_data[31:28]));
                end
            end
        end
        o_pending = status_q.size();
    end

endmodule

@@ tb/tb_pcm_sample_fifo_with_volume.sv @@
// Testbench top for the PCM sample FIFO with master volume: stimulus and verdict.
module tb_pcm_sample_fifo_with_volume;

    localparam int DEPTH = 1024;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int ROUND_BEATS = 90;
    localparam int FILL_SAMPLES = 100;
    localparam logic [psfv_pkg::OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [psfv_pkg::OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    int          failures;
    int          pending;
    int          cycle_count = 0;
    logic        steady = 1'b0;
    logic        hold_off_req = 1'b0;

    pcm_sample_fifo_with_volume #(
        .FIFO_DEPTH(DEPTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    pcm_fifo_checker #(
        .DEPTH(DEPTH)
    ) checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (s_axis_tvalid),
        .i_in_ready (s_axis_tready),
        .i_in_data  (s_axis_tdata),
        .i_in_op    (s_axis_tuser),
        .i_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_out_data (m_axis_tdata),
        .o_failures (failures),
        .o_pending  (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL pcm_sample_fifo_with_volume");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Output side: random stalls, plus one long hold-off on request.
    initial begin
        int stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
                stall_left = 0;
            end else if (stall_left > 0 && !steady) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = 0;
                if (!steady && $urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic send_beat(input logic [psfv_pkg::OP_W-1:0] op, input logic [7:0] data);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 40)
            gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= data;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_sample(input logic [7:0] hi, input logic [7:0] lo);
        send_beat(psfv_pkg::OP_LATCH_HI, hi);
        send_beat(psfv_pkg::OP_PUSH_LO, lo);
    endtask

    // Stop offering beats and hold until every predicted beat has come out.
    task automatic drain_outputs();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_volume(input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [7:0] round_vol [6];
        int         beats;
        int         r;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // Directed: empty pull, count read, unused codes, flag writes, sample extremes.
        write_volume(8'hFF);
        send_beat(psfv_pkg::OP_PULL, 8'hFF);
        send_beat(psfv_pkg::OP_READ_COUNT, 8'h00);
        for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
            send_beat(op[psfv_pkg::OP_W-1:0], 8'hFF);
        send_beat(psfv_pkg::OP_WRITE_FLAGS, 8'h03);
        send_beat(psfv_pkg::OP_WRITE_FLAGS, 8'h00);
        send_beat(psfv_pkg::OP_WRITE_FLAGS, 8'h01);
        send_beat(psfv_pkg::OP_WRITE_FLAGS, 8'h02);
        send_beat(psfv_pkg::OP_WRITE_FLAGS, 8'h00);
        send_sample(8'h80, 8'h00);
        send_sample(8'h7F, 8'hFF);
        send_beat(psfv_pkg::OP_PUSH_LO, 8'h5A);  // push with the latch already cleared
        send_sample(8'hFF, 8'hFF);
        send_beat(psfv_pkg::OP_LATCH_HI, 8'h12);
        send_sample(8'h34, 8'h56);    // second latch overwrites the first
        repeat (6) send_beat(psfv_pkg::OP_PULL, 8'h00);
        drain_outputs();

        // Fill part way under a long output hold-off, then empty it.
        write_volume(8'h5B);
        for (int i = 0; i < FILL_SAMPLES; i++) begin
            if (i == 20)
                hold_off_req = 1'b1;
            send_sample(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        send_beat(psfv_pkg::OP_READ_COUNT, 8'h00);
        send_beat(psfv_pkg::OP_WRITE_FLAGS, 8'h00);
        send_sample(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        send_beat(psfv_pkg::OP_PULL, 8'h00);
        send_sample(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        send_sample(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        for (int i = 0; i < FILL_SAMPLES + 3; i++) begin
            if (i == 30)
                send_beat(psfv_pkg::OP_WRITE_FLAGS, 8'h01);
            if (i == 70)
                send_beat(psfv_pkg::OP_WRITE_FLAGS, 8'h00);
            send_beat(psfv_pkg::OP_PULL, 8'($urandom_range(0, 255)));
        end
        drain_outputs();

        // Random rounds, one volume setting each.
        round_vol[0] = 8'h00;
        round_vol[1] = 8'hA5;
        round_vol[2] = 8'h7E;
        round_vol[3] = 8'($urandom_range(0, 255));
        round_vol[4] = 8'hFF;
        round_vol[5] = 8'hC8;
        for (int round = 0; round < 6; round++) begin
            write_volume(round_vol[round]);
            steady = (round == 2);
            beats = 0;
            while (beats < ROUND_BEATS) begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    send_sample(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    beats += 2;
                end else begin
                    if (r < 80)
                        send_beat(psfv_pkg::OP_PULL, 8'($urandom_range(0, 255)));
                    else if (r < 85)
                        send_beat(psfv_pkg::OP_PUSH_LO, 8'($urandom_range(0, 255)));
                    else if (r < 90)
                        send_beat(psfv_pkg::OP_LATCH_HI, 8'($urandom_range(0, 255)));
                    else if (r < 94)
                        send_beat(psfv_pkg::OP_READ_COUNT, 8'($urandom_range(0, 255)));
                    else if (r < 97)
                        send_beat(psfv_pkg::OP_WRITE_FLAGS, 8'($urandom_range(0, 255)));
                    else
                        send_beat(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                                  8'($urandom_range(0, 255)));
                    beats++;
                end
            end
            steady = 1'b0;
            drain_outputs();
        end

        if (failures == 0 && pending == 0)
            $display("PASS pcm_sample_fifo_with_volume");
        else
            $display("FAIL pcm_sample_fifo_with_volume");
        $finish;
    end

endmodule
